>>> rtl/cvs_pkg.sv
// shared types and constants for the circle visual servo step pipeline
// used by cvs_div and circle_visual_servo_step_unit; no dependencies
package cvs_pkg;

    // register indexes on the configuration port
    localparam logic [2:0] CFG_FOCAL    = 3'd0;
    localparam logic [2:0] CFG_IMG_W    = 3'd1;
    localparam logic [2:0] CFG_IMG_H    = 3'd2;
    localparam logic [2:0] CFG_DIAM     = 3'd3;
    localparam logic [2:0] CFG_DES_U    = 3'd4;
    localparam logic [2:0] CFG_DES_V    = 3'd5;
    localparam logic [2:0] CFG_DES_SIZE = 3'd6;
    localparam logic [2:0] CFG_GAIN     = 3'd7;

    // status codes
    localparam logic [1:0] ST_MOVE    = 2'd0;
    localparam logic [1:0] ST_HOVER   = 2'd1;
    localparam logic [1:0] ST_OUTSIDE = 2'd2;

    // divider geometry
    localparam int NUM_W      = 68;
    localparam int DEN_W      = 38;
    localparam int REM_W      = 38;
    localparam int QUO_W      = 32;
    localparam int DIV_BITS   = 2;
    localparam int DIV_STAGES = QUO_W / DIV_BITS;
    localparam int DIV_LAT    = DIV_STAGES + 2;

    // datapath widths
    localparam int M_W   = 34;
    localparam int E_W   = 33;
    localparam int PR_W  = 51;
    localparam int ACC_W = 72;

    // squared workspace radius 0.85^2 in Q56
    localparam logic [65:0] WS_LIMIT = (66'd289 << 52) / 66'd25;

    typedef struct packed {
        logic [15:0] focal;
        logic [11:0] img_w;
        logic [11:0] img_h;
        logic [15:0] diam;
        logic [15:0] des_u;
        logic [15:0] des_v;
        logic [15:0] des_size;
        logic [15:0] gain;
    } t_cfg;

    localparam t_cfg CFG_RESET = '{
        focal: 16'd500, img_w: 12'd640, img_h: 12'd480, diam: 16'd6554,
        des_u: 16'd5120, des_v: 16'd3840, des_size: 16'd1280, gain: 16'd6554
    };

endpackage

>>> rtl/cvs_div.sv
// pipelined rounding divider: two quotient bits a stage, rounds halves away
// from zero, applies sign and saturates to 32 bits; uses cvs_pkg
module cvs_div (
    input  logic                              i_clk,
    input  logic                              i_en,
    input  logic [cvs_pkg::NUM_W-1:0]         i_num,
    input  logic [cvs_pkg::DEN_W-1:0]         i_den,
    input  logic                              i_neg,
    output logic signed [cvs_pkg::QUO_W-1:0]  o_quo
);
    import cvs_pkg::*;

    typedef struct packed {
        logic             sat;
        logic             neg;
        logic [DEN_W-1:0] den;
        logic [REM_W-1:0] rem;
        logic [QUO_W-1:0] sh;   // numerator bits out at the top, quotient bits in at the bottom
    } t_div_st;

    // a few restoring steps
    function automatic t_div_st div_steps(input t_div_st s);
        t_div_st          o;
        logic [REM_W:0]   tmp;
        o = s;
        for (int k = 0; k < DIV_BITS; k++) begin
            tmp  = {o.rem, o.sh[QUO_W-1]};
            o.sh = {o.sh[QUO_W-2:0], 1'b0};
            if (tmp >= {1'b0, o.den}) begin
                tmp     = tmp - {1'b0, o.den};
                o.sh[0] = 1'b1;
            end
            o.rem = tmp[REM_W-1:0];
        end
        return o;
    endfunction

    t_div_st                  r_st [DIV_STAGES+1];
    logic                     n_sat;
    logic                     n_up;
    logic [QUO_W:0]           n_q1;
    logic [QUO_W:0]           n_lim;
    logic [QUO_W:0]           n_mag;
    logic [QUO_W:0]           n_val;
    logic signed [QUO_W-1:0]  r_quo;

    // quotient would need more than 32 bits
    assign n_sat = {2'b0, i_num} >= {i_den, 32'b0};

    // final rounding and saturation
    always_comb begin
        n_up  = {r_st[DIV_STAGES].rem, 1'b0} >= {1'b0, r_st[DIV_STAGES].den};
        n_q1  = {1'b0, r_st[DIV_STAGES].sh} + {{QUO_W{1'b0}}, n_up};
        n_lim = r_st[DIV_STAGES].neg ? {2'b01, {(QUO_W-1){1'b0}}}
                                     : {2'b00, {(QUO_W-1){1'b1}}};
        n_mag = (r_st[DIV_STAGES].sat || n_q1 > n_lim) ? n_lim : n_q1;
        n_val = r_st[DIV_STAGES].neg ? (~n_mag + 1'b1) : n_mag;
    end

    // stage registers
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_st[0] <= '{sat: n_sat, neg: i_neg, den: i_den,
                         rem: REM_W'(i_num[NUM_W-1:QUO_W]), sh: i_num[QUO_W-1:0]};
            for (int s = 1; s <= DIV_STAGES; s++) begin
                r_st[s] <= div_steps(r_st[s-1]);
            end
            r_quo <= $signed(n_val[QUO_W-1:0]);
        end
    end

    assign o_quo = r_quo;

endmodule

>>> rtl/circle_visual_servo_step_unit.sv
// top level of the circle visual servo step: stream ports, registers,
// front arithmetic, rotation and workspace check; uses cvs_pkg and cvs_div

// One request in, one result out, one request per cycle sustained. The pipeline
// has five front stages (offsets, products, numerator factors and rotation
// matrix, partial products of the numerators, full dividends), 18 registers in
// the pipelined divider that produces two quotient bits a stage for the three
// camera-frame steps, and five back stages (rotation products, accumulate,
// round and saturate, squares, workspace compare and output register). The
// whole pipeline advances whenever the output register is empty or taken; a
// held result halts it without loss. Status travels on tuser: move, hover for
// zero radius (target repeats the position) or outside workspace.
module circle_visual_servo_step_unit (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_cfg_wen,
    input  logic [2:0]   i_cfg_idx,
    input  logic [15:0]  i_cfg_data,
    input  logic         i_s_tvalid,
    output logic         o_s_tready,
    // center_x, center_y, radius, pos_x, pos_y, pos_z, quat_w, quat_i, quat_j, quat_k
    input  logic [207:0] i_s_tdata,
    output logic         o_m_tvalid,
    input  logic         i_m_tready,
    // target_x, target_y, target_z
    output logic [95:0]  o_m_tdata,
    // status
    output logic [1:0]   o_m_tuser
);
    import cvs_pkg::*;

    typedef struct packed {
        logic               v;
        logic [15:0]        rad;
        logic signed [16:0] eu;
        logic signed [16:0] ev;
        logic signed [17:0] es;
        logic signed [16:0] u;
        logic signed [16:0] vv;
        logic [95:0]        pos;
        logic signed [15:0] qa, qb, qc, qd;
    } t_s1;

    typedef struct packed {
        logic               v;
        logic               hover;
        logic [95:0]        pos;
        logic signed [34:0] ues, ves, reu, rev;
        logic [31:0]        rr;
        logic [31:0]        gd;
        logic [32:0]        esf;
        logic               esneg;
        logic signed [31:0] aa, bb, cc, dd, bc, ad, bd, ac, cd, ab;
    } t_s2;

    typedef struct packed {
        logic                  v;
        logic                  hover;
        logic [95:0]           pos;
        logic [8:0][M_W-1:0]   m;
        logic [35:0]           nxm, nym, nzm;
        logic                  nxneg, nyneg, nzneg;
        logic [31:0]           gd;
        logic [DEN_W-1:0]      dxy, dz;
    } t_s3;

    typedef struct packed {
        logic                  v;
        logic                  hover;
        logic [95:0]           pos;
        logic [8:0][M_W-1:0]   m;
        logic                  nxneg, nyneg, nzneg;
        logic [DEN_W-1:0]      dxy, dz;
        logic [49:0]           xl, xh, yl, yh, zl, zh;
    } t_s4;

    typedef struct packed {
        logic                  v;
        logic                  hover;
        logic [95:0]           pos;
        logic [8:0][M_W-1:0]   m;
        logic                  nxneg, nyneg, nzneg;
        logic [DEN_W-1:0]      dxy, dz;
        logic [NUM_W-1:0]      nx, ny, nz;
    } t_s5;

    typedef struct packed {
        logic                  v;
        logic                  hover;
        logic [95:0]           pos;
        logic [8:0][M_W-1:0]   m;
    } t_side;

    typedef struct packed {
        logic                  v;
        logic                  hover;
        logic [95:0]           pos;
        logic [8:0][PR_W-1:0]  pl, ph;
    } t_p1;

    typedef struct packed {
        logic                  v;
        logic                  hover;
        logic [95:0]           pos;
        logic [2:0][ACC_W-1:0] acc;
    } t_p2;

    typedef struct packed {
        logic        v;
        logic        hover;
        logic [95:0] t;
    } t_p3;

    typedef struct packed {
        logic            v;
        logic            hover;
        logic [95:0]     t;
        logic [2:0][63:0] sq;
    } t_p4;

    typedef struct packed {
        logic        v;
        logic [1:0]  status;
        logic [95:0] t;
    } t_out;

    t_cfg  r_cfg;
    t_s1   r_s1, n_s1;
    t_s2   r_s2, n_s2;
    t_s3   r_s3, n_s3;
    t_s4   r_s4, n_s4;
    t_s5   r_s5, n_s5;
    t_side r_sd [DIV_LAT];
    t_p1   r_p1, n_p1;
    t_p2   r_p2, n_p2;
    t_p3   r_p3, n_p3;
    t_p4   r_p4, n_p4;
    t_out  r_out, n_out;
    logic  en;

    logic signed [QUO_W-1:0] sx, sy, sz;
    logic signed [E_W-1:0]   e [3];
    logic signed [16:0]      elo [3];
    logic signed [16:0]      ehi [3];

    // whole pipeline moves unless a result is held at the output
    assign en         = !r_out.v || i_m_tready;
    assign o_s_tready = en;
    assign o_m_tvalid = r_out.v;
    assign o_m_tdata  = r_out.t;
    assign o_m_tuser  = r_out.status;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= CFG_RESET;
        end else if (i_cfg_wen) begin
            unique case (i_cfg_idx)
                CFG_FOCAL:    r_cfg.focal    <= i_cfg_data;
                CFG_IMG_W:    r_cfg.img_w    <= i_cfg_data[11:0];
                CFG_IMG_H:    r_cfg.img_h    <= i_cfg_data[11:0];
                CFG_DIAM:     r_cfg.diam     <= i_cfg_data;
                CFG_DES_U:    r_cfg.des_u    <= i_cfg_data;
                CFG_DES_V:    r_cfg.des_v    <= i_cfg_data;
                CFG_DES_SIZE: r_cfg.des_size <= i_cfg_data;
                CFG_GAIN:     r_cfg.gain     <= i_cfg_data;
            endcase
        end
    end

    // stage 1: feature errors and re-centred coordinates
    always_comb begin
        n_s1.v   = i_s_tvalid;
        n_s1.rad = i_s_tdata[47:32];
        n_s1.eu  = $signed({1'b0, r_cfg.des_u}) - $signed({1'b0, i_s_tdata[15:0]});
        n_s1.ev  = $signed({1'b0, r_cfg.des_v}) - $signed({1'b0, i_s_tdata[31:16]});
        n_s1.es  = $signed({2'b0, r_cfg.des_size}) - $signed({1'b0, i_s_tdata[47:32], 1'b0});
        n_s1.u   = $signed({1'b0, i_s_tdata[15:0]}) - $signed({2'b0, r_cfg.img_w, 3'b0});
        n_s1.vv  = $signed({1'b0, i_s_tdata[31:16]}) - $signed({2'b0, r_cfg.img_h, 3'b0});
        n_s1.pos = i_s_tdata[143:48];
        n_s1.qa  = $signed(i_s_tdata[159:144]);
        n_s1.qb  = $signed(i_s_tdata[175:160]);
        n_s1.qc  = $signed(i_s_tdata[191:176]);
        n_s1.qd  = $signed(i_s_tdata[207:192]);
    end

    // stage 2: first products
    always_comb begin
        logic signed [17:0] r2;
        logic [16:0]        esm;
        r2          = $signed({1'b0, r_s1.rad, 1'b0});
        esm         = r_s1.es[17] ? 17'(-r_s1.es) : r_s1.es[16:0];
        n_s2.v      = r_s1.v;
        n_s2.hover  = (r_s1.rad == 16'd0);
        n_s2.pos    = r_s1.pos;
        n_s2.ues    = 35'(r_s1.u) * 35'(r_s1.es);
        n_s2.ves    = 35'(r_s1.vv) * 35'(r_s1.es);
        n_s2.reu    = 35'(r2) * 35'(r_s1.eu);
        n_s2.rev    = 35'(r2) * 35'(r_s1.ev);
        n_s2.rr     = r_s1.rad * r_s1.rad;
        n_s2.gd     = r_cfg.gain * r_cfg.diam;
        n_s2.esf    = esm * r_cfg.focal;
        n_s2.esneg  = r_s1.es[17];
        n_s2.aa     = r_s1.qa * r_s1.qa;
        n_s2.bb     = r_s1.qb * r_s1.qb;
        n_s2.cc     = r_s1.qc * r_s1.qc;
        n_s2.dd     = r_s1.qd * r_s1.qd;
        n_s2.bc     = r_s1.qb * r_s1.qc;
        n_s2.ad     = r_s1.qa * r_s1.qd;
        n_s2.bd     = r_s1.qb * r_s1.qd;
        n_s2.ac     = r_s1.qa * r_s1.qc;
        n_s2.cd     = r_s1.qc * r_s1.qd;
        n_s2.ab     = r_s1.qa * r_s1.qb;
    end

    // stage 3: numerator factors, denominators and rotation matrix
    always_comb begin
        logic signed [35:0] nx, ny;
        nx          = 36'(r_s2.ues) - 36'(r_s2.reu);
        ny          = 36'(r_s2.ves) - 36'(r_s2.rev);
        n_s3.v      = r_s2.v;
        n_s3.hover  = r_s2.hover;
        n_s3.pos    = r_s2.pos;
        n_s3.nxneg  = nx[35];
        n_s3.nyneg  = ny[35];
        n_s3.nzneg  = r_s2.esneg;
        n_s3.nxm    = nx[35] ? 36'(-nx) : nx;
        n_s3.nym    = ny[35] ? 36'(-ny) : ny;
        n_s3.nzm    = {3'b0, r_s2.esf};
        n_s3.gd     = r_s2.gd;
        n_s3.dxy    = {r_s2.rr, 6'b0};
        n_s3.dz     = {4'b0, r_s2.rr, 2'b0};
        n_s3.m[0]   = M_W'(r_s2.aa) + M_W'(r_s2.bb) - M_W'(r_s2.cc) - M_W'(r_s2.dd);
        n_s3.m[1]   = (M_W'(r_s2.bc) - M_W'(r_s2.ad)) <<< 1;
        n_s3.m[2]   = (M_W'(r_s2.bd) + M_W'(r_s2.ac)) <<< 1;
        n_s3.m[3]   = (M_W'(r_s2.bc) + M_W'(r_s2.ad)) <<< 1;
        n_s3.m[4]   = M_W'(r_s2.aa) - M_W'(r_s2.bb) + M_W'(r_s2.cc) - M_W'(r_s2.dd);
        n_s3.m[5]   = (M_W'(r_s2.cd) - M_W'(r_s2.ab)) <<< 1;
        n_s3.m[6]   = (M_W'(r_s2.bd) - M_W'(r_s2.ac)) <<< 1;
        n_s3.m[7]   = (M_W'(r_s2.cd) + M_W'(r_s2.ab)) <<< 1;
        n_s3.m[8]   = M_W'(r_s2.aa) - M_W'(r_s2.bb) - M_W'(r_s2.cc) + M_W'(r_s2.dd);
    end

    // stage 4: partial products of the dividends, split in 18-bit halves
    always_comb begin
        n_s4.v     = r_s3.v;
        n_s4.hover = r_s3.hover;
        n_s4.pos   = r_s3.pos;
        n_s4.m     = r_s3.m;
        n_s4.nxneg = r_s3.nxneg;
        n_s4.nyneg = r_s3.nyneg;
        n_s4.nzneg = r_s3.nzneg;
        n_s4.dxy   = r_s3.dxy;
        n_s4.dz    = r_s3.dz;
        n_s4.xl    = r_s3.gd * r_s3.nxm[17:0];
        n_s4.xh    = r_s3.gd * r_s3.nxm[35:18];
        n_s4.yl    = r_s3.gd * r_s3.nym[17:0];
        n_s4.yh    = r_s3.gd * r_s3.nym[35:18];
        n_s4.zl    = r_s3.gd * r_s3.nzm[17:0];
        n_s4.zh    = r_s3.gd * r_s3.nzm[35:18];
    end

    // stage 5: full dividends
    always_comb begin
        n_s5.v     = r_s4.v;
        n_s5.hover = r_s4.hover;
        n_s5.pos   = r_s4.pos;
        n_s5.m     = r_s4.m;
        n_s5.nxneg = r_s4.nxneg;
        n_s5.nyneg = r_s4.nyneg;
        n_s5.nzneg = r_s4.nzneg;
        n_s5.dxy   = r_s4.dxy;
        n_s5.dz    = r_s4.dz;
        n_s5.nx    = {18'b0, r_s4.xl} + {r_s4.xh, 18'b0};
        n_s5.ny    = {18'b0, r_s4.yl} + {r_s4.yh, 18'b0};
        n_s5.nz    = {18'b0, r_s4.zl} + {r_s4.zh, 18'b0};
    end

    // camera-frame steps
    cvs_div u_div_x (
        .i_clk (i_clk), .i_en (en), .i_num (r_s5.nx), .i_den (r_s5.dxy),
        .i_neg (r_s5.nxneg), .o_quo (sx)
    );
    cvs_div u_div_y (
        .i_clk (i_clk), .i_en (en), .i_num (r_s5.ny), .i_den (r_s5.dxy),
        .i_neg (r_s5.nyneg), .o_quo (sy)
    );
    cvs_div u_div_z (
        .i_clk (i_clk), .i_en (en), .i_num (r_s5.nz), .i_den (r_s5.dz),
        .i_neg (r_s5.nzneg), .o_quo (sz)
    );

    // end-effector frame step (-y, x, z) split for the rotation products
    always_comb begin
        e[0] = -E_W'(sy);
        e[1] = E_W'(sx);
        e[2] = E_W'(sz);
        for (int j = 0; j < 3; j++) begin
            elo[j] = $signed({1'b0, e[j][15:0]});
            ehi[j] = e[j][E_W-1:16];
        end
    end

    // back stage 1: rotation partial products
    always_comb begin
        n_p1.v     = r_sd[DIV_LAT-1].v;
        n_p1.hover = r_sd[DIV_LAT-1].hover;
        n_p1.pos   = r_sd[DIV_LAT-1].pos;
        for (int k = 0; k < 9; k++) begin
            n_p1.pl[k] = PR_W'($signed(r_sd[DIV_LAT-1].m[k])) * PR_W'(elo[k % 3]);
            n_p1.ph[k] = PR_W'($signed(r_sd[DIV_LAT-1].m[k])) * PR_W'(ehi[k % 3]);
        end
    end

    // back stage 2: position plus rotated step, Q58
    always_comb begin
        logic signed [ACC_W-1:0] s;
        n_p2.v     = r_p1.v;
        n_p2.hover = r_p1.hover;
        n_p2.pos   = r_p1.pos;
        for (int i = 0; i < 3; i++) begin
            s = ACC_W'($signed(r_p1.pos[32*i +: 32])) <<< 30;
            for (int j = 0; j < 3; j++) begin
                s = s + (ACC_W'($signed(r_p1.ph[3*i+j])) <<< 16)
                      + ACC_W'($signed(r_p1.pl[3*i+j]));
            end
            n_p2.acc[i] = s;
        end
    end

    // back stage 3: round to Q28 and saturate, hover keeps the position
    always_comb begin
        logic signed [ACC_W-1:0] rs;
        n_p3.v     = r_p2.v;
        n_p3.hover = r_p2.hover;
        for (int i = 0; i < 3; i++) begin
            rs = ($signed(r_p2.acc[i]) + ACC_W'(64'sd536870912)) >>> 30;
            if (r_p2.hover) begin
                n_p3.t[32*i +: 32] = r_p2.pos[32*i +: 32];
            end else if (rs > ACC_W'(64'sd2147483647)) begin
                n_p3.t[32*i +: 32] = 32'h7FFF_FFFF;
            end else if (rs < ACC_W'(-64'sd2147483648)) begin
                n_p3.t[32*i +: 32] = 32'h8000_0000;
            end else begin
                n_p3.t[32*i +: 32] = rs[31:0];
            end
        end
    end

    // back stage 4: squares of the target coordinates
    always_comb begin
        logic [31:0] mg;
        n_p4.v     = r_p3.v;
        n_p4.hover = r_p3.hover;
        n_p4.t     = r_p3.t;
        for (int i = 0; i < 3; i++) begin
            mg = r_p3.t[32*i+31] ? (~r_p3.t[32*i +: 32] + 32'd1) : r_p3.t[32*i +: 32];
            n_p4.sq[i] = mg * mg;
        end
    end

    // output stage: workspace check and status
    always_comb begin
        logic [65:0] sum;
        sum     = {2'b0, r_p4.sq[0]} + {2'b0, r_p4.sq[1]} + {2'b0, r_p4.sq[2]};
        n_out.v = r_p4.v;
        n_out.t = r_p4.t;
        priority if (r_p4.hover) begin
            n_out.status = ST_HOVER;
        end else if (sum > WS_LIMIT) begin
            n_out.status = ST_OUTSIDE;
        end else begin
            n_out.status = ST_MOVE;
        end
    end

    // pipeline registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1.v  <= 1'b0;
            r_s2.v  <= 1'b0;
            r_s3.v  <= 1'b0;
            r_s4.v  <= 1'b0;
            r_s5.v  <= 1'b0;
            for (int k = 0; k < DIV_LAT; k++) begin
                r_sd[k].v <= 1'b0;
            end
            r_p1.v  <= 1'b0;
            r_p2.v  <= 1'b0;
            r_p3.v  <= 1'b0;
            r_p4.v  <= 1'b0;
            r_out.v <= 1'b0;
        end else if (en) begin
            r_s1  <= n_s1;
            r_s2  <= n_s2;
            r_s3  <= n_s3;
            r_s4  <= n_s4;
            r_s5  <= n_s5;
            r_sd[0] <= '{v: r_s5.v, hover: r_s5.hover, pos: r_s5.pos, m: r_s5.m};
            for (int k = 1; k < DIV_LAT; k++) begin
                r_sd[k] <= r_sd[k-1];
            end
            r_p1  <= n_p1;
            r_p2  <= n_p2;
            r_p3  <= n_p3;
            r_p4  <= n_p4;
            r_out <= n_out;
        end
    end

`ifndef ASSERT_OFF
    // reset empties the output register
    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> !o_m_tvalid)
        else $error("output valid after reset");

    // a held result freezes the pipeline valid bits
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !en |=> $stable(r_s5.v) && $stable(r_sd[DIV_LAT-1].v) && $stable(r_p4.v))
        else $error("pipeline moved during stall");

    // hover items leave with hover status
    a_hover_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        en && r_p4.v && r_p4.hover |=> o_m_tvalid && r_out.status == ST_HOVER)
        else $error("hover item lost its status");

    // only hover items carry hover status
    a_status_hover_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        en && r_p4.v && !r_p4.hover |=> r_out.status != ST_HOVER)
        else $error("hover status without zero radius");
`endif

endmodule

>>> verif/tb.sv
// self-checking bench for circle_visual_servo_step_unit: directed and random requests
// against a bit-exact predictor; depends on cvs_pkg and the rtl top level
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import cvs_pkg::*;

    typedef struct {
        logic [15:0] cx, cy, rad;
        logic signed [31:0] px, py, pz;
        logic signed [15:0] qw, qi, qj, qk;
    } t_request;

    typedef struct {
        logic [1:0] status;
        logic signed [31:0] tx, ty, tz;
    } t_result;

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         i_cfg_wen = 1'b0;
    logic [2:0]   i_cfg_idx = '0;
    logic [15:0]  i_cfg_data = '0;
    logic         i_s_tvalid = 1'b0;
    logic         o_s_tready;
    // center_x, center_y, radius, pos_x, pos_y, pos_z, quat_w, quat_i, quat_j, quat_k
    logic [207:0] i_s_tdata = '0;
    logic         o_m_tvalid;
    logic         i_m_tready = 1'b0;
    // target_x, target_y, target_z
    logic [95:0]  o_m_tdata;
    // status
    logic [1:0]   o_m_tuser;

    circle_visual_servo_step_unit dut (.*);

    always #4 i_clk = ~i_clk;

    t_cfg     shadow_cfg = CFG_RESET;
    t_request pending_q[$];
    t_result  target_q[$];
    int       mismatches = 0;
    int       n_sent = 0, n_got = 0, n_hover = 0, n_outside = 0;
    bit       calm = 1'b0;
    int       hold_req = 0;
    int       hold_cnt = 0;
    int       quiet = 0;

    function automatic longint unsigned absval(longint x);
        return x < 0 ? longint'(0) - x : x;
    endfunction

    // round(a*b/den) halves away from zero, signed, clamped to 32 bits
    function automatic longint step_quot(logic [63:0] fa, logic [63:0] fb, bit neg,
                                         logic [63:0] den);
        logic [127:0] num, q, r, lim;
        num = {64'd0, fa} * {64'd0, fb};
        q = num / {64'd0, den};
        r = num % {64'd0, den};
        if (2 * r >= {64'd0, den}) q = q + 1;
        lim = neg ? 128'h8000_0000 : 128'h7FFF_FFFF;
        if (q > lim) q = lim;
        return neg ? -longint'(q[63:0]) : longint'(q[63:0]);
    endfunction

    // camera step, frame change, position update and workspace status
    function automatic t_result predict_target(t_request rq);
        t_result res;
        longint eu, ev, es, u, v, nx, ny, rad, den, a, b, c, d, t;
        longint mm[3][3];
        longint stp[3];
        longint pos[3];
        logic [63:0] gd;
        logic signed [127:0] acc, prod;
        logic [127:0] sumsq;
        pos[0] = rq.px; pos[1] = rq.py; pos[2] = rq.pz;
        if (rq.rad == 0) begin
            res.status = ST_HOVER;
            res.tx = rq.px; res.ty = rq.py; res.tz = rq.pz;
            return res;
        end
        rad = rq.rad;
        eu = longint'(shadow_cfg.des_u) - longint'(rq.cx);
        ev = longint'(shadow_cfg.des_v) - longint'(rq.cy);
        es = longint'(shadow_cfg.des_size) - 2 * rad;
        u = longint'(rq.cx) - 8 * longint'(shadow_cfg.img_w);
        v = longint'(rq.cy) - 8 * longint'(shadow_cfg.img_h);
        gd = 64'(shadow_cfg.gain) * 64'(shadow_cfg.diam);
        nx = u * es - 2 * rad * eu;
        ny = v * es - 2 * rad * ev;
        den = rad * rad;
        stp[1] = step_quot(gd, absval(nx), nx < 0, 64 * den);
        stp[0] = -step_quot(gd, absval(ny), ny < 0, 64 * den);
        stp[2] = step_quot(gd, absval(es) * longint'(shadow_cfg.focal), es < 0, 4 * den);
        a = rq.qw; b = rq.qi; c = rq.qj; d = rq.qk;
        mm[0][0] = a*a + b*b - c*c - d*d;
        mm[0][1] = 2 * (b*c - a*d);
        mm[0][2] = 2 * (b*d + a*c);
        mm[1][0] = 2 * (b*c + a*d);
        mm[1][1] = a*a - b*b + c*c - d*d;
        mm[1][2] = 2 * (c*d - a*b);
        mm[2][0] = 2 * (b*d - a*c);
        mm[2][1] = 2 * (c*d + a*b);
        mm[2][2] = a*a - b*b - c*c + d*d;
        sumsq = '0;
        for (int i = 0; i < 3; i++) begin
            acc = pos[i];
            acc = acc <<< 30;
            for (int j = 0; j < 3; j++) begin
                prod = mm[i][j];
                prod = prod * stp[j];
                acc = acc + prod;
            end
            acc = (acc + (128'sd1 <<< 29)) >>> 30;
            if (acc > 128'sh7FFF_FFFF) t = 64'sh7FFF_FFFF;
            else if (acc < -128'sh8000_0000) t = -64'sh8000_0000;
            else t = longint'(acc);
            if (i == 0) res.tx = t; else if (i == 1) res.ty = t; else res.tz = t;
            sumsq = sumsq + 128'(t * t);
        end
        res.status = (sumsq > 128'(WS_LIMIT)) ? ST_OUTSIDE : ST_MOVE;
        return res;
    endfunction

    function automatic logic [207:0] pack_request(t_request rq);
        return {rq.qk, rq.qj, rq.qi, rq.qw, rq.pz, rq.py, rq.px, rq.rad, rq.cy, rq.cx};
    endfunction

    // sender: offers requests and records the expected result on acceptance
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_s_tvalid && o_s_tready) begin
                t_request rq;
                rq.cx = i_s_tdata[15:0];     rq.cy = i_s_tdata[31:16];
                rq.rad = i_s_tdata[47:32];   rq.px = i_s_tdata[79:48];
                rq.py = i_s_tdata[111:80];   rq.pz = i_s_tdata[143:112];
                rq.qw = i_s_tdata[159:144];  rq.qi = i_s_tdata[175:160];
                rq.qj = i_s_tdata[191:176];  rq.qk = i_s_tdata[207:192];
                target_q.push_back(predict_target(rq));
                n_sent++;
            end
            if (!i_s_tvalid || o_s_tready) begin
                if (pending_q.size() > 0 && (calm || $urandom_range(99) >= 31)) begin
                    i_s_tvalid <= 1'b1;
                    i_s_tdata <= pack_request(pending_q.pop_front());
                end else begin
                    i_s_tvalid <= 1'b0;
                end
            end
        end
    end

    // receiver: random stalls plus a requested long hold-off
    always @(posedge i_clk) begin
        if (hold_cnt > 0) begin
            hold_cnt <= hold_cnt - 1;
            i_m_tready <= 1'b0;
        end else if (hold_req > 0) begin
            hold_cnt <= hold_req;
            hold_req <= 0;
            i_m_tready <= 1'b0;
        end else begin
            i_m_tready <= calm || ($urandom_range(99) >= 31);
        end
    end

    // result checker
    always @(posedge i_clk) begin
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            t_result got, want;
            got.status = o_m_tuser;
            got.tx = o_m_tdata[31:0];
            got.ty = o_m_tdata[63:32];
            got.tz = o_m_tdata[95:64];
            n_got++;
            if (target_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result %p", got);
            end else begin
                want = target_q.pop_front();
                if (got.status == ST_HOVER) n_hover++;
                if (got.status == ST_OUTSIDE) n_outside++;
                if (got.status !== want.status || got.tx !== want.tx ||
                    got.ty !== want.ty || got.tz !== want.tz) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected %p got %p", want, got);
                end
            end
        end
    end

    // watchdog on cycles without progress while work is outstanding
    always @(posedge i_clk) begin
        if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready) ||
            (pending_q.size() == 0 && target_q.size() == 0 && !i_s_tvalid)) begin
            quiet <= 0;
        end else if (quiet >= 5000) begin
            $display("timeout with %0d results outstanding", target_q.size());
            $display("tb failed");
            $finish;
        end else begin
            quiet <= quiet + 1;
        end
    end

    task automatic write_reg(logic [2:0] idx, logic [15:0] val);
        @(posedge i_clk);
        i_cfg_wen <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= val;
        case (idx)
            CFG_FOCAL:    shadow_cfg.focal = val;
            CFG_IMG_W:    shadow_cfg.img_w = val[11:0];
            CFG_IMG_H:    shadow_cfg.img_h = val[11:0];
            CFG_DIAM:     shadow_cfg.diam = val;
            CFG_DES_U:    shadow_cfg.des_u = val;
            CFG_DES_V:    shadow_cfg.des_v = val;
            CFG_DES_SIZE: shadow_cfg.des_size = val;
            default:      shadow_cfg.gain = val;
        endcase
        @(posedge i_clk);
        i_cfg_wen <= 1'b0;
    endtask

    task automatic load_cfg(t_cfg cf);
        write_reg(CFG_FOCAL, cf.focal);
        write_reg(CFG_IMG_W, 16'(cf.img_w));
        write_reg(CFG_IMG_H, 16'(cf.img_h));
        write_reg(CFG_DIAM, cf.diam);
        write_reg(CFG_DES_U, cf.des_u);
        write_reg(CFG_DES_V, cf.des_v);
        write_reg(CFG_DES_SIZE, cf.des_size);
        write_reg(CFG_GAIN, cf.gain);
    endtask

    task automatic drain_pipe();
        while (pending_q.size() > 0 || i_s_tvalid || target_q.size() > 0)
            @(posedge i_clk);
        repeat (40) @(posedge i_clk);
    endtask

    // plausible scene around the image centre, with a rough unit quaternion or a random one
    function automatic t_request scene_request();
        t_request rq;
        rq.cx = 16'(16 * int'(shadow_cfg.img_w) / 2 + $urandom_range(4000) - 2000);
        rq.cy = 16'(16 * int'(shadow_cfg.img_h) / 2 + $urandom_range(4000) - 2000);
        rq.rad = $urandom_range(2000, 40);
        rq.px = $urandom_range(2**28) - 2**27;
        rq.py = $urandom_range(2**28) - 2**27;
        rq.pz = $urandom_range(2**28) - 2**27;
        case ($urandom_range(3))
            0: begin rq.qw = 32767; rq.qi = 0; rq.qj = 0; rq.qk = 0; end
            1: begin rq.qw = 23170; rq.qi = 0; rq.qj = 0; rq.qk = 23170; end
            2: begin rq.qw = 0; rq.qi = 23170; rq.qj = -16'sd23170; rq.qk = 0; end
            default: begin
                rq.qw = $urandom_range(32767); rq.qi = $urandom_range(16000) - 8000;
                rq.qj = $urandom_range(16000) - 8000; rq.qk = $urandom_range(16000) - 8000;
            end
        endcase
        return rq;
    endfunction

    function automatic t_request noise_request();
        t_request rq;
        rq.cx = $urandom; rq.cy = $urandom; rq.rad = $urandom;
        if ($urandom_range(7) == 0) rq.rad = 0;
        rq.px = $urandom; rq.py = $urandom; rq.pz = $urandom;
        rq.qw = $urandom; rq.qi = $urandom; rq.qj = $urandom; rq.qk = $urandom;
        return rq;
    endfunction

    task automatic queue_random(int n);
        repeat (n) begin
            if ($urandom_range(99) < 75) pending_q.push_back(scene_request());
            else pending_q.push_back(noise_request());
        end
    endtask

    task automatic queue_directed();
        t_request rq;
        rq = scene_request();
        rq.qw = 32767; rq.qi = 0; rq.qj = 0; rq.qk = 0;
        pending_q.push_back(rq);
        // hover keeps the position, extremes included
        rq.rad = 0; rq.px = 32'sh7FFF_FFFF; rq.py = 32'sh8000_0000; rq.pz = 0;
        pending_q.push_back(rq);
        rq.rad = 0; rq.px = -1; rq.py = 1; rq.pz = 32'sh8000_0000;
        pending_q.push_back(rq);
        // smallest and largest radius
        rq = scene_request(); rq.rad = 1; pending_q.push_back(rq);
        rq = scene_request(); rq.rad = 16'hFFFF; pending_q.push_back(rq);
        // size just past the target, then also centred on the target
        rq = scene_request(); rq.rad = shadow_cfg.des_size / 2 + 1; pending_q.push_back(rq);
        rq.cx = shadow_cfg.des_u; rq.cy = shadow_cfg.des_v; pending_q.push_back(rq);
        // centre extremes
        rq = scene_request(); rq.cx = 0; rq.cy = 0; rq.rad = 3; pending_q.push_back(rq);
        rq.cx = 16'hFFFF; rq.cy = 16'hFFFF; pending_q.push_back(rq);
        // position at the saturation edges
        rq = scene_request(); rq.px = 32'sh7FFF_FFFF; rq.py = 32'sh7FFF_FFFF;
        rq.pz = 32'sh7FFF_FFFF; pending_q.push_back(rq);
        rq.px = 32'sh8000_0000; rq.py = 32'sh8000_0000; rq.pz = 32'sh8000_0000;
        pending_q.push_back(rq);
        // a hover request, then a position at the workspace edge on x
        rq = scene_request(); rq.rad = 0; pending_q.push_back(rq);
        rq = scene_request(); rq.px = 32'sd228170137; rq.py = 0; rq.pz = 0;
        pending_q.push_back(rq);
        // degenerate quaternions: zero, all most negative, all most positive
        rq = scene_request(); rq.qw = 0; rq.qi = 0; rq.qj = 0; rq.qk = 0; pending_q.push_back(rq);
        rq.qw = -16'sd32768; rq.qi = -16'sd32768; rq.qj = -16'sd32768; rq.qk = -16'sd32768;
        pending_q.push_back(rq);
        rq.qw = 32767; rq.qi = 32767; rq.qj = 32767; rq.qk = 32767; rq.rad = 1;
        pending_q.push_back(rq);
        rq = noise_request(); rq.rad = 1; pending_q.push_back(rq);
    endtask

    // phases: defaults, upper and lower register extremes, random settings, defaults again
    initial begin
        t_cfg cf;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        queue_directed();
        queue_random(250);
        drain_pipe();

        cf = '{focal: 16'hFFFF, img_w: 12'hFFF, img_h: 12'hFFF, diam: 16'hFFFF,
               des_u: 16'hFFFF, des_v: 16'hFFFF, des_size: 16'hFFFF, gain: 16'hFFFF};
        load_cfg(cf);
        queue_directed();
        queue_random(200);
        drain_pipe();

        cf = '{focal: 16'd1, img_w: 12'd1, img_h: 12'd1, diam: 16'd1,
               des_u: 16'd0, des_v: 16'd0, des_size: 16'd0, gain: 16'd0};
        load_cfg(cf);
        queue_directed();
        queue_random(120);
        drain_pipe();

        repeat (3) begin
            cf.focal = $urandom_range(65535, 1); cf.img_w = $urandom_range(4095, 1);
            cf.img_h = $urandom_range(4095, 1); cf.diam = $urandom_range(65535, 1);
            cf.des_u = $urandom; cf.des_v = $urandom; cf.des_size = $urandom;
            cf.gain = $urandom;
            load_cfg(cf);
            queue_random(200);
            drain_pipe();
        end

        // back to defaults: a calm stretch, then a long output hold-off
        load_cfg(CFG_RESET);
        calm = 1'b1;
        queue_random(200);
        drain_pipe();
        calm = 1'b0;
        queue_random(150);
        hold_req = 400;
        queue_random(150);
        drain_pipe();

        $display("%0d requests, %0d results (%0d hover, %0d outside) over 7 register phases",
                 n_sent, n_got, n_hover, n_outside);
        if (mismatches == 0) begin
            $display("tb passed");
        end else begin
            $display("%0d mismatches", mismatches);
            $display("tb failed");
        end
        $finish;
    end
endmodule

>>> filelist.f
rtl/cvs_pkg.sv
rtl/cvs_div.sv
rtl/circle_visual_servo_step_unit.sv
verif/tb.sv
